>>> rtl/core/hptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hptc_pkg - heading PI turn controller shared definitions
// Field widths, angle constants, configuration indexes and the structs that
// pass between the pipeline stages.
// ----------------------------------------------------------------------------
package hptc_pkg;

    // Field and datapath widths
    localparam int HEAD_W    = 24;  // heading, Q15.8
    localparam int TURN_W    = 18;  // requested turn, Q9.8
    localparam int TGT_W     = 25;  // target heading
    localparam int ERR_W     = 26;  // heading error
    localparam int INTEG_W   = 24;  // clamped integral, |x| <= 32767*256
    localparam int ISUM_W    = 27;  // integral plus previous error
    localparam int GAIN_W    = 16;  // Q8.8 gains
    localparam int LIM_W     = 15;  // speed limit
    localparam int MOTOR_W   = 16;  // motor commands
    localparam int PROD_P_W  = 42;  // prop_gain * error
    localparam int PROD_I_W  = 40;  // integ_gain * integral
    localparam int SUM_W     = 43;  // product sum, Q.16
    localparam int CORR_W    = 27;  // correction after the Q.16 drop
    localparam int FRAC_W    = 16;  // fraction bits dropped from the sum
    localparam int CFG_W     = 16;  // widest configuration register
    localparam int CFG_IDX_W = 2;

    // Angles in Q.8 degrees
    localparam logic signed [ERR_W-1:0] ONE_DEG   = 26'sd256;
    localparam logic signed [ERR_W-1:0] HALF_TURN = 26'sd46080;
    localparam logic signed [ERR_W-1:0] FULL_TURN = 26'sd92160;
    localparam logic signed [TURN_W-1:0] ONE_DEG_TURN = 18'sd256;

    // Item kinds
    localparam logic MODE_START  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 2'd0,
        CFG_INTEG_GAIN  = 2'd1,
        CFG_SPEED_LIMIT = 2'd2,
        CFG_SENSOR      = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic [LIM_W-1:0]         speed_limit;
        logic                     sensor_present;
    } cfg_t;

    typedef struct packed {
        logic                     mode;
        logic signed [HEAD_W-1:0] heading;
        logic signed [TURN_W-1:0] turn_request;
    } item_t;

    // Control step handed from the state stage to the arithmetic stages
    typedef struct packed {
        logic                      drive;
        logic                      done;
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
    } ctl_t;

endpackage

>>> rtl/core/hptc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hptc_in_if - input item channel
// Valid/ready channel carrying one start or heading sample item.
// ----------------------------------------------------------------------------
interface hptc_in_if;
    import hptc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic signed [HEAD_W-1:0] heading;
    logic signed [TURN_W-1:0] turn_request;

    modport source (output valid, output mode, output heading, output turn_request,
                    input ready);
    modport sink (input valid, input mode, input heading, input turn_request,
                  output ready);
endinterface

>>> rtl/core/hptc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hptc_out_if - result channel
// Valid/ready channel carrying the motor commands and turn status.
// ----------------------------------------------------------------------------
interface hptc_out_if;
    import hptc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [MOTOR_W-1:0] motor_left;
    logic signed [MOTOR_W-1:0] motor_right;
    logic                      drive_valid;
    logic                      turn_done;

    modport source (output valid, output motor_left, output motor_right,
                    output drive_valid, output turn_done, input ready);
    modport sink (input valid, input motor_left, input motor_right,
                  input drive_valid, input turn_done, output ready);
endinterface

>>> rtl/core/hptc_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hptc_state - controller state stage
// Holds target, integral, previous error and the turning flag; forms the
// wrapped error and the clamped integral for each transfer.
// ----------------------------------------------------------------------------
module hptc_state (
    input  logic            clk,
    input  logic            rst_n,
    input  hptc_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  hptc_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output hptc_pkg::ctl_t  out_ctl
);
    import hptc_pkg::*;

    logic signed [TGT_W-1:0]   target_reg, target_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [ERR_W-1:0]   prev_err_reg, prev_err_next;
    logic                      turning_reg, turning_next;
    logic                      st_valid_reg;
    ctl_t                      st_reg, st_next;

    logic                      in_fire;
    logic signed [ERR_W-1:0]   err_raw, err_hi, err_wrap;
    logic signed [ISUM_W-1:0]  isum, lim_q;
    logic signed [INTEG_W-1:0] integ_clamp;
    logic                      near;
    logic                      turn_big;

    // Accept when the stage is empty or its content moves on
    assign in_ready  = !st_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = st_valid_reg;
    assign out_ctl   = st_reg;

    // Error against target, wrapped once into half a turn either way
    assign err_raw  = ERR_W'(target_reg) - ERR_W'(in_item.heading);
    assign err_hi   = (err_raw > HALF_TURN) ? (err_raw - FULL_TURN) : err_raw;
    assign err_wrap = (err_hi < -HALF_TURN) ? (err_hi + FULL_TURN) : err_hi;
    assign near     = (err_wrap <= ONE_DEG) && (err_wrap >= -ONE_DEG);

    // Integral plus previous error, clamped to the speed limit in degrees
    assign lim_q = $signed({4'b0000, cfg.speed_limit, 8'h00});
    assign isum  = ISUM_W'(integ_reg) + ISUM_W'(prev_err_reg);
    always_comb
    begin
        if (isum > lim_q)
        begin
            integ_clamp = INTEG_W'(lim_q);
        end
        else if (isum < -lim_q)
        begin
            integ_clamp = INTEG_W'(-lim_q);
        end
        else
        begin
            integ_clamp = INTEG_W'(isum);
        end
    end

    assign turn_big = (in_item.turn_request > ONE_DEG_TURN)
                   || (in_item.turn_request < -ONE_DEG_TURN);

    // Next state and control step for the item in hand
    always_comb
    begin
        target_next   = target_reg;
        integ_next    = integ_reg;
        prev_err_next = prev_err_reg;
        turning_next  = turning_reg;
        st_next.drive = 1'b0;
        st_next.done  = 1'b1;
        st_next.err   = err_wrap;
        st_next.integ = integ_clamp;
        if (in_item.mode == MODE_START)
        begin
            target_next   = TGT_W'(in_item.heading) - TGT_W'(in_item.turn_request);
            integ_next    = '0;
            prev_err_next = '0;
            turning_next  = cfg.sensor_present && turn_big;
            st_next.done  = !(cfg.sensor_present && turn_big);
        end
        else if (turning_reg && cfg.sensor_present)
        begin
            integ_next    = integ_clamp;
            prev_err_next = err_wrap;
            turning_next  = !near;
            st_next.drive = 1'b1;
            st_next.done  = near;
        end
        else
        begin
            turning_next = 1'b0;
        end
    end

    // Update state and stage register on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            integ_reg    <= '0;
            prev_err_reg <= '0;
            turning_reg  <= 1'b0;
            st_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                target_reg   <= target_next;
                integ_reg    <= integ_next;
                prev_err_reg <= prev_err_next;
                turning_reg  <= turning_next;
                st_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                st_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            st_reg <= st_next;
        end
    end

    // A turn only begins from a start transfer with cleared history
    a_turn_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(turning_reg) |-> integ_reg == '0 && prev_err_reg == '0)
        else $error("turn began without cleared integral");

    a_rose_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !turning_reg && in_item.mode == MODE_SAMPLE |=> !turning_reg)
        else $error("sample transfer started a turn");

    a_idle_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !turning_reg |=> st_valid_reg && !st_reg.drive)
        else $error("idle controller produced a drive step");

endmodule

>>> rtl/core/hptc_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hptc_calc - PI correction pipeline
// Multiplies error and integral by their gains, sums, drops the Q.16
// fraction toward zero and saturates both motor commands.
// ----------------------------------------------------------------------------
module hptc_calc (
    input  logic           clk,
    input  logic           rst_n,
    input  hptc_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  hptc_pkg::ctl_t in_ctl,
    hptc_out_if.source     result_out
);
    import hptc_pkg::*;

    // Product stage
    logic                       p_valid_reg;
    logic                       p_drive_reg, p_done_reg;
    logic signed [PROD_P_W-1:0] prod_p_reg, prod_p_next;
    logic signed [PROD_I_W-1:0] prod_i_reg, prod_i_next;
    logic                       p_ready;

    // Sum stage
    logic                       s_valid_reg;
    logic                       s_drive_reg, s_done_reg;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic                       s_ready;

    // Output stage
    logic                       o_valid_reg;
    logic                       o_drive_reg, o_done_reg;
    logic signed [MOTOR_W-1:0]  ml_reg, ml_next;
    logic signed [MOTOR_W-1:0]  mr_reg, mr_next;
    logic                       o_ready;

    logic signed [CORR_W-1:0]   corr;
    logic signed [CORR_W-1:0]   lim_c;
    logic                       round_up;

    // Stall chain: each stage loads when empty or draining
    assign o_ready  = !o_valid_reg || result_out.ready;
    assign s_ready  = !s_valid_reg || o_ready;
    assign p_ready  = !p_valid_reg || s_ready;
    assign in_ready = p_ready;

    // Gain products
    assign prod_p_next = PROD_P_W'(in_ctl.err) * PROD_P_W'(cfg.prop_gain);
    assign prod_i_next = PROD_I_W'(in_ctl.integ) * PROD_I_W'(cfg.integ_gain);

    // Product sum in Q.16
    assign sum_next = SUM_W'(prod_p_reg) + SUM_W'(prod_i_reg);

    // Drop the fraction toward zero, then saturate
    assign round_up = sum_reg[SUM_W-1] && (|sum_reg[FRAC_W-1:0]);
    assign corr     = sum_reg[SUM_W-1:FRAC_W] + CORR_W'(round_up);
    assign lim_c    = $signed({{(CORR_W-LIM_W){1'b0}}, cfg.speed_limit});
    always_comb
    begin
        if (!s_drive_reg)
        begin
            ml_next = '0;
        end
        else if (corr > lim_c)
        begin
            ml_next = MOTOR_W'(lim_c);
        end
        else if (corr < -lim_c)
        begin
            ml_next = MOTOR_W'(-lim_c);
        end
        else
        begin
            ml_next = MOTOR_W'(corr);
        end
        mr_next = -ml_next;
    end

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_ready)
            begin
                p_valid_reg <= in_valid;
            end
            if (s_ready)
            begin
                s_valid_reg <= p_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= s_valid_reg;
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (p_ready && in_valid)
        begin
            prod_p_reg  <= prod_p_next;
            prod_i_reg  <= prod_i_next;
            p_drive_reg <= in_ctl.drive;
            p_done_reg  <= in_ctl.done;
        end
        if (s_ready && p_valid_reg)
        begin
            sum_reg     <= sum_next;
            s_drive_reg <= p_drive_reg;
            s_done_reg  <= p_done_reg;
        end
        if (o_ready && s_valid_reg)
        begin
            ml_reg      <= ml_next;
            mr_reg      <= mr_next;
            o_drive_reg <= s_drive_reg;
            o_done_reg  <= s_done_reg;
        end
    end

    assign result_out.valid       = o_valid_reg;
    assign result_out.motor_left  = ml_reg;
    assign result_out.motor_right = mr_reg;
    assign result_out.drive_valid = o_drive_reg;
    assign result_out.turn_done   = o_done_reg;

    a_motors_opposed: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> mr_reg == -ml_reg)
        else $error("motor commands not opposed");

    a_no_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && !o_drive_reg |-> ml_reg == '0 && mr_reg == '0)
        else $error("motor command without control step");

endmodule

>>> rtl/core/heading_pi_turn_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_pi_turn_controller_core - PI turn-in-place controller
// Start items set a target heading; sample items during a turn run one PI
// step with angle wrap and drive two saturated, opposed motor commands.
// ----------------------------------------------------------------------------
// One item is accepted every clock cycle unless backpressure stalls the
// input, and each gives exactly one result, passing through an input
// register, the state stage (error wrap, integral clamp and turn flag,
// updated on each transfer so consecutive samples follow directly), a
// gain multiply stage, a sum stage and the output register with
// the truncation and saturation. Backpressure stalls only the stages that
// are full. Configuration writes take effect on the next cycle and are meant
// to be made while no item is in flight.
module heading_pi_turn_controller_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hptc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hptc_pkg::CFG_W-1:0]         cfg_data,
    hptc_in_if.sink                            item_in,
    hptc_out_if.source                         result_out
);
    import hptc_pkg::*;

    cfg_t  cfg_reg;
    item_t in_reg;
    logic  in_valid_reg;
    logic  st_in_ready;
    logic  st_valid;
    logic  calc_ready;
    ctl_t  st_ctl;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain      <= 16'sd256;
            cfg_reg.integ_gain     <= 16'sd0;
            cfg_reg.speed_limit    <= 15'd100;
            cfg_reg.sensor_present <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PROP_GAIN:   cfg_reg.prop_gain      <= $signed(cfg_data);
                CFG_INTEG_GAIN:  cfg_reg.integ_gain     <= $signed(cfg_data);
                CFG_SPEED_LIMIT: cfg_reg.speed_limit    <= cfg_data[LIM_W-1:0];
                CFG_SENSOR:      cfg_reg.sensor_present <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Input register
    assign item_in.ready = !in_valid_reg || st_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_in.ready)
        begin
            in_valid_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.ready && item_in.valid)
        begin
            in_reg.mode         <= item_in.mode;
            in_reg.heading      <= item_in.heading;
            in_reg.turn_request <= item_in.turn_request;
        end
    end

    hptc_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid_reg),
        .in_ready  (st_in_ready),
        .in_item   (in_reg),
        .out_valid (st_valid),
        .out_ready (calc_ready),
        .out_ctl   (st_ctl)
    );

    hptc_calc u_calc (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (st_valid),
        .in_ready   (calc_ready),
        .in_ctl     (st_ctl),
        .result_out (result_out)
    );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - heading PI turn controller testbench
// Walks a short table of directed transfers and register settings, then runs
// random turn episodes (a start followed by heading samples homing in on the
// target) under several idle and stall patterns, checking every result against
// a table entry or an in-bench model of the controller state and PI arithmetic.
// ----------------------------------------------------------------------------
module tb;
    import hptc_pkg::*;

    typedef struct packed {
        logic signed [MOTOR_W-1:0] motor_left;
        logic signed [MOTOR_W-1:0] motor_right;
        logic                      drive_valid;
        logic                      turn_done;
    } drive_res_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        cfg_idx_t         idx;
        logic [CFG_W-1:0] val;
        item_t            it;
        logic             typed;
        drive_res_t       res;
    } stim_row_t;

    // Results that can be read off directly
    localparam drive_res_t RES_IDLE  = '{16'sd0, 16'sd0, 1'b0, 1'b1};
    localparam drive_res_t RES_ARMED = '{16'sd0, 16'sd0, 1'b0, 1'b0};
    localparam drive_res_t RES_HELD  = '{16'sd0, 16'sd0, 1'b1, 1'b0};
    localparam item_t      NO_ITEM   = '{MODE_START, 24'sd0, 18'sd0};

    localparam int DIR_ROWS  = 35;
    localparam int PHASES    = 8;
    localparam int PHASE_LEN = 75;
    localparam int HOLD_LEN  = 300;

    localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
        // sensor absent after reset: everything answers idle
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_SAMPLE, 24'sd0, 18'sd0}, 1'b1, RES_IDLE},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_START, 24'sh7FFFFF, 18'sd92160}, 1'b1,
          RES_IDLE},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_SAMPLE, 24'sh800000, -18'sd92160}, 1'b1,
          RES_IDLE},
        '{ROW_CFG, CFG_SENSOR, 16'd1, NO_ITEM, 1'b0, RES_IDLE},
        // a turn of exactly one degree does not arm
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_START, 24'sd0, 18'sd256}, 1'b1, RES_IDLE},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_SAMPLE, 24'sd0, 18'sd0}, 1'b1, RES_IDLE},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_START, 24'sd0, -18'sd257}, 1'b1, RES_ARMED},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_SAMPLE, 24'sd0, 18'sd0}, 1'b0, RES_IDLE},
        // within a degree: drives once more, then idles
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_SAMPLE, 24'sd300, 18'sd0}, 1'b0, RES_IDLE},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_SAMPLE, 24'sd5, 18'sd0}, 1'b1, RES_IDLE},
        // heading extremes and wrap of the error
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_START, 24'sh7FFFFF, -18'sd92160}, 1'b1,
          RES_ARMED},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_SAMPLE, 24'sh800000, 18'sd0}, 1'b0, RES_IDLE},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_SAMPLE, 24'sh7FFFFF, 18'sd0}, 1'b0, RES_IDLE},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_START, 24'sd100, 18'sd92160}, 1'b1, RES_ARMED},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_SAMPLE, 24'sd0, 18'sd0}, 1'b0, RES_IDLE},
        // gain and limit extremes
        '{ROW_CFG, CFG_PROP_GAIN, 16'h7FFF, NO_ITEM, 1'b0, RES_IDLE},
        '{ROW_CFG, CFG_INTEG_GAIN, 16'h8000, NO_ITEM, 1'b0, RES_IDLE},
        '{ROW_CFG, CFG_SPEED_LIMIT, 16'h7FFF, NO_ITEM, 1'b0, RES_IDLE},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_START, 24'sd0, 18'sd46080}, 1'b1, RES_ARMED},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_SAMPLE, 24'sd0, 18'sd0}, 1'b0, RES_IDLE},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_SAMPLE, 24'sh7FFFFF, 18'sd0}, 1'b0, RES_IDLE},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_SAMPLE, -24'sd45000, 18'sd0}, 1'b0, RES_IDLE},
        // zero speed limit holds the motors at zero
        '{ROW_CFG, CFG_SPEED_LIMIT, 16'd0, NO_ITEM, 1'b0, RES_IDLE},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_START, 24'sd0, -18'sd5000}, 1'b1, RES_ARMED},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_SAMPLE, 24'sd100, 18'sd0}, 1'b1, RES_HELD},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_SAMPLE, 24'sd200, 18'sd0}, 1'b1, RES_HELD},
        // sensor lost mid-turn
        '{ROW_CFG, CFG_SENSOR, 16'd0, NO_ITEM, 1'b0, RES_IDLE},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_SAMPLE, 24'sd300, 18'sd0}, 1'b1, RES_IDLE},
        '{ROW_CFG, CFG_PROP_GAIN, 16'h8000, NO_ITEM, 1'b0, RES_IDLE},
        '{ROW_CFG, CFG_INTEG_GAIN, 16'h7FFF, NO_ITEM, 1'b0, RES_IDLE},
        '{ROW_CFG, CFG_SPEED_LIMIT, 16'd100, NO_ITEM, 1'b0, RES_IDLE},
        '{ROW_CFG, CFG_SENSOR, 16'd1, NO_ITEM, 1'b0, RES_IDLE},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_START, 24'sh800000, -18'sd92160}, 1'b1,
          RES_ARMED},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_SAMPLE, 24'sd0, 18'sd0}, 1'b0, RES_IDLE},
        '{ROW_ITEM, CFG_PROP_GAIN, 16'd0, '{MODE_SAMPLE, -24'sd8296648, 18'sd0}, 1'b0,
          RES_IDLE}
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    cfg_idx_t           cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    hptc_in_if  in_ch ();
    hptc_out_if out_ch ();

    heading_pi_turn_controller_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_in    (in_ch),
        .result_out (out_ch)
    );

    // Model copy of the registers and controller state
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic [LIM_W-1:0]         spd_lim;
    logic                     sensor_ok;
    longint                   tgt_hd;
    longint                   integ_acc;
    longint                   last_err;
    logic                     turning;

    drive_res_t pending_drives [$];

    int err_cnt;
    int n_items;
    int n_starts;
    int n_checked;
    int n_steps;
    int n_finished;
    int send_pct;
    int recv_pct;
    int hold_reqs;

    function automatic longint clamp_l(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Advance the controller model by one item and return its result
    function automatic drive_res_t predict_drive(item_t it);
        longint     hd;
        longint     trn;
        longint     err;
        longint     acc;
        longint     corr;
        longint     lim;
        drive_res_t res;
        hd  = longint'($signed(it.heading));
        trn = longint'($signed(it.turn_request));
        lim = longint'(spd_lim);
        res = RES_IDLE;
        if (it.mode == MODE_START)
        begin
            tgt_hd    = hd - trn;
            integ_acc = 0;
            last_err  = 0;
            turning   = sensor_ok && (trn > longint'(ONE_DEG) || trn < -longint'(ONE_DEG));
            res.turn_done = !turning;
        end
        else
        begin
            if (turning && !sensor_ok)
                turning = 1'b0;
            if (turning)
            begin
                err = tgt_hd - hd;
                if (err > longint'(HALF_TURN))
                    err -= longint'(FULL_TURN);
                if (err < -longint'(HALF_TURN))
                    err += longint'(FULL_TURN);
                integ_acc = clamp_l(integ_acc + last_err, lim * longint'(ONE_DEG));
                last_err  = err;
                acc  = longint'(gain_p) * err + longint'(gain_i) * integ_acc;
                corr = acc / 65536;
                res.motor_left  = MOTOR_W'(clamp_l(corr, lim));
                res.motor_right = MOTOR_W'(clamp_l(-corr, lim));
                res.drive_valid = 1'b1;
                if (err <= longint'(ONE_DEG) && err >= -longint'(ONE_DEG))
                begin
                    res.turn_done = 1'b1;
                    turning       = 1'b0;
                end
                else
                begin
                    res.turn_done = 1'b0;
                end
            end
        end
        return res;
    endfunction

    // Drop valid and hold until every expected result has arrived
    task automatic stop_and_drain();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_drives.size() != 0);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
        stop_and_drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PROP_GAIN:   gain_p    = val;
            CFG_INTEG_GAIN:  gain_i    = val;
            CFG_SPEED_LIMIT: spd_lim   = val[LIM_W-1:0];
            CFG_SENSOR:      sensor_ok = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Offer one item, optionally after an idle gap, and log its expected result
    task automatic send_item(item_t it, logic typed, drive_res_t typed_res);
        int         gap;
        drive_res_t res;
        gap = 0;
        while (send_pct > 0 && gap < 40 && $urandom_range(99) < send_pct)
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= it.mode;
        in_ch.heading      <= it.heading;
        in_ch.turn_request <= it.turn_request;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        res = predict_drive(it);
        pending_drives.push_back(typed ? typed_res : res);
        n_items++;
        if (it.mode == MODE_START)
            n_starts++;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side: check each transfer, then pick ready for the next cycle
    initial
    begin
        int         hold_seen;
        int         hold_left;
        drive_res_t got;
        drive_res_t want;
        hold_seen = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                got = '{out_ch.motor_left, out_ch.motor_right,
                        out_ch.drive_valid, out_ch.turn_done};
                if (pending_drives.size() == 0)
                begin
                    $display("%0t: unexpected result l=%0d r=%0d drv=%0b done=%0b",
                             $time, got.motor_left, got.motor_right,
                             got.drive_valid, got.turn_done);
                    err_cnt++;
                end
                else
                begin
                    want = pending_drives.pop_front();
                    n_checked++;
                    if (want.drive_valid)
                        n_steps++;
                    if (want.drive_valid && want.turn_done)
                        n_finished++;
                    if (got.motor_left !== want.motor_left
                        || got.motor_right !== want.motor_right
                        || got.drive_valid !== want.drive_valid
                        || got.turn_done !== want.turn_done)
                    begin
                        $display("%0t: mismatch expected l=%0d r=%0d drv=%0b done=%0b",
                                 $time, want.motor_left, want.motor_right,
                                 want.drive_valid, want.turn_done);
                        $display("%0t:          actual   l=%0d r=%0d drv=%0b done=%0b",
                                 $time, got.motor_left, got.motor_right,
                                 got.drive_valid, got.turn_done);
                        err_cnt++;
                    end
                end
            end
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (recv_pct > 0)
            begin
                out_ch.ready <= ($urandom_range(99) >= recv_pct);
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Run limit
    initial
    begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus
    initial
    begin
        item_t            it;
        stim_row_t        row;
        logic [CFG_W-1:0] gp;
        logic [CFG_W-1:0] gi;
        logic [CFG_W-1:0] sl;
        logic             sens;
        longint           e;
        longint           hd;
        int               phase_start;
        int               n_samp;
        int               sel;
        bit               held;
        bit               paused;

        err_cnt    = 0;
        n_items    = 0;
        n_starts   = 0;
        n_checked  = 0;
        n_steps    = 0;
        n_finished = 0;
        send_pct   = 0;
        recv_pct   = 0;
        hold_reqs  = 0;
        held       = 1'b0;
        paused     = 1'b0;
        gain_p     = 16'sd256;
        gain_i     = 16'sd0;
        spd_lim    = 15'd100;
        sensor_ok  = 1'b0;
        tgt_hd     = 0;
        integ_acc  = 0;
        last_err   = 0;
        turning    = 1'b0;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_PROP_GAIN;
        cfg_data           <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.mode         <= MODE_START;
        in_ch.heading      <= '0;
        in_ch.turn_request <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = DIR_TAB[i];
            if (row.kind == ROW_CFG)
                write_reg(row.idx, row.val);
            else
                send_item(row.it, row.typed, row.res);
        end

        // Random phases, one idle pattern and one register setting each
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_pct = 0;
                    recv_pct = 0;
                end
                1:
                begin
                    send_pct = 62;
                    recv_pct = 0;
                end
                2:
                begin
                    send_pct = 0;
                    recv_pct = 62;
                end
                default:
                begin
                    send_pct = 32;
                    recv_pct = 32;
                end
            endcase
            if (ph == 2)
            begin
                gp = 16'h7FFF;
                gi = 16'h8000;
                sl = 16'h7FFF;
            end
            else if (ph == 5)
            begin
                gp = 16'h8000;
                gi = 16'h7FFF;
                sl = 16'd0;
            end
            else
            begin
                gp = ($urandom_range(7) == 0) ? 16'($urandom)
                                              : 16'(int'($urandom_range(2048)) - 1024);
                gi = ($urandom_range(7) == 0) ? 16'($urandom)
                                              : 16'(int'($urandom_range(512)) - 256);
                sl = ($urandom_range(3) == 0) ? 16'($urandom_range(32767))
                                              : 16'($urandom_range(3000, 1));
            end
            sens = (ph == 0) ? 1'b1 : ($urandom_range(4) != 0);
            write_reg(CFG_PROP_GAIN, gp);
            write_reg(CFG_INTEG_GAIN, gi);
            write_reg(CFG_SPEED_LIMIT, sl);
            write_reg(CFG_SENSOR, {15'd0, sens});

            phase_start = n_items;
            while (n_items - phase_start < PHASE_LEN)
            begin
                // Long receiver hold-off with the sender still pushing
                if (ph == 0 && !held && n_items - phase_start >= 20)
                begin
                    hold_reqs++;
                    held = 1'b1;
                end
                // Sender pause until the pipeline is empty
                if (ph == 3 && !paused && n_items - phase_start >= 40)
                begin
                    stop_and_drain();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 10)
                begin
                    // noise: any item at all
                    it.mode         = 1'($urandom_range(1));
                    it.heading      = HEAD_W'($urandom);
                    it.turn_request = TURN_W'(int'($urandom_range(184320)) - 92160);
                    send_item(it, 1'b0, RES_IDLE);
                end
                else
                begin
                    // turn episode: start, then samples around the target
                    it.mode    = MODE_START;
                    it.heading = HEAD_W'($urandom);
                    if ($urandom_range(4) != 0)
                        it.turn_request = TURN_W'(int'($urandom_range(92160, 257)));
                    else
                        it.turn_request = TURN_W'(int'($urandom_range(300)));
                    if ($urandom_range(1))
                        it.turn_request = -it.turn_request;
                    send_item(it, 1'b0, RES_IDLE);
                    n_samp = $urandom_range(10, 2);
                    for (int s = 0; s < n_samp; s++)
                    begin
                        sel = $urandom_range(99);
                        if (sel < 30)
                            e = longint'($urandom_range(600)) - 300;
                        else if (sel < 80)
                            e = longint'($urandom_range(92160)) - 46080;
                        else
                            e = longint'($urandom_range(276480)) - 138240;
                        hd = tgt_hd - e;
                        while (hd > 64'sd8388607)
                            hd -= longint'(FULL_TURN);
                        while (hd < -64'sd8388608)
                            hd += longint'(FULL_TURN);
                        it.mode         = MODE_SAMPLE;
                        it.heading      = (sel >= 95) ? HEAD_W'($urandom) : HEAD_W'(hd);
                        it.turn_request = TURN_W'($urandom);
                        send_item(it, 1'b0, RES_IDLE);
                    end
                end
            end
        end

        stop_and_drain();
        repeat (20) @(posedge clk);

        $display("Covered %0d items (%0d starts) over %0d register settings;", n_items,
                 n_starts, PHASES + 1);
        $display("checked %0d results, %0d control steps, %0d turns brought within a degree.",
                 n_checked, n_steps, n_finished);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
